@@ hdl/aats_pkg.sv @@
// Package for the actuator angle-to-steps block: operation codes, command and
// status structs, fixed-point constants and the Horner coefficient tables.
// No dependencies.
`default_nettype none

package aats_pkg;

  localparam int unsigned MACHINES_DEF = 8;

  // angles in 1/64 degree
  localparam logic [14:0] FULL_TURN    = 15'd23040;
  localparam logic [14:0] HALF_TURN    = 15'd11520;
  localparam logic [14:0] QUARTER_TURN = 15'd5760;
  localparam logic [14:0] EIGHTH_TURN  = 15'd2880;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [31:0] RAD_PER_UNIT = 32'd292818;

  localparam int unsigned HORNER_LAST  = 4;
  localparam int unsigned ROOT_LAST    = 24;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ARM_B     = 3'd0,
    REG_ARM_C     = 3'd1,
    REG_ZERO      = 3'd2,
    REG_OBTUSE    = 3'd3,
    REG_GEAR      = 3'd4,
    REG_REVERSE   = 3'd5,
    REG_STEPS     = 3'd6,
    REG_UNUSED    = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE    = 5'd0,
    OP_CAPTURE = 5'd1,
    OP_BB      = 5'd2,
    OP_CC      = 5'd3,
    OP_BC      = 5'd4,
    OP_GLO     = 5'd5,
    OP_GHI     = 5'd6,
    OP_FOLD    = 5'd7,
    OP_X       = 5'd8,
    OP_X2      = 5'd9,
    OP_HN      = 5'd10,
    OP_HQ      = 5'd11,
    OP_HR      = 5'd12,
    OP_SIN     = 5'd13,
    OP_CA      = 5'd14,
    OP_CB      = 5'd15,
    OP_SQ      = 5'd16,
    OP_ROOT    = 5'd17,
    OP_LEN     = 5'd18,
    OP_MH      = 5'd19,
    OP_ML      = 5'd20,
    OP_TOT     = 5'd21
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] stage;  // Horner stage
    logic [4:0] cnt;    // root iteration
    logic       pass;   // 0 old angle, 1 new angle
  } cmd_t;

  typedef struct packed {
    logic sin;          // folded angle uses the sine series
  } status_t;

  // Horner divisor for a stage
  function automatic logic [6:0] horner_k(input logic sin, input logic [2:0] stage);
    logic [6:0] k;
    k = 7'd1;
    unique case ({sin, stage})
      4'b0_000: k = 7'd90;
      4'b0_001: k = 7'd56;
      4'b0_010: k = 7'd30;
      4'b0_011: k = 7'd12;
      4'b0_100: k = 7'd2;
      4'b1_000: k = 7'd110;
      4'b1_001: k = 7'd72;
      4'b1_010: k = 7'd42;
      4'b1_011: k = 7'd20;
      4'b1_100: k = 7'd6;
      default:  k = 7'd1;
    endcase
    return k;
  endfunction

  // floor(2^32 / k) for the same stage
  function automatic logic [31:0] horner_r(input logic sin, input logic [2:0] stage);
    logic [31:0] r;
    r = 32'd0;
    unique case ({sin, stage})
      4'b0_000: r = 32'd47721858;
      4'b0_001: r = 32'd76695844;
      4'b0_010: r = 32'd143165576;
      4'b0_011: r = 32'd357913941;
      4'b0_100: r = 32'd2147483648;
      4'b1_000: r = 32'd39045157;
      4'b1_001: r = 32'd59652323;
      4'b1_010: r = 32'd102261126;
      4'b1_011: r = 32'd214748364;
      4'b1_100: r = 32'd715827882;
      default:  r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/aats_ctrl.sv @@
// Sequencer for the angle-to-steps block: walks each item through the
// datapath operations and owns both handshakes. Depends on aats_pkg.
`default_nettype none

module aats_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  aats_pkg::status_t  status_i,
  output aats_pkg::cmd_t     cmd_o
);
  import aats_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE = 21'h000001,
    ST_BB   = 21'h000002,
    ST_CC   = 21'h000004,
    ST_BC   = 21'h000008,
    ST_GLO  = 21'h000010,
    ST_GHI  = 21'h000020,
    ST_FOLD = 21'h000040,
    ST_X    = 21'h000080,
    ST_X2   = 21'h000100,
    ST_HN   = 21'h000200,
    ST_HQ   = 21'h000400,
    ST_HR   = 21'h000800,
    ST_SIN  = 21'h001000,
    ST_CA   = 21'h002000,
    ST_CB   = 21'h004000,
    ST_SQ   = 21'h008000,
    ST_ROOT = 21'h010000,
    ST_LEN  = 21'h020000,
    ST_MH   = 21'h040000,
    ST_ML   = 21'h080000,
    ST_TOT  = 21'h100000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] stage_q, stage_d;
  logic [4:0] cnt_q, cnt_d;
  logic       pass_q, pass_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OP_NONE;
    cmd_o.stage = stage_q;
    cmd_o.cnt   = cnt_q;
    cmd_o.pass  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = ST_BB;
        end
      end
      ST_BB: begin cmd_o.op = OP_BB; state_d = ST_CC; end
      ST_CC: begin cmd_o.op = OP_CC; state_d = ST_BC; end
      ST_BC: begin cmd_o.op = OP_BC; state_d = ST_GLO; end
      ST_GLO: begin cmd_o.op = OP_GLO; state_d = ST_GHI; end
      ST_GHI: begin
        cmd_o.op = OP_GHI;
        pass_d   = 1'b0;
        state_d  = ST_FOLD;
      end
      ST_FOLD: begin cmd_o.op = OP_FOLD; state_d = ST_X; end
      ST_X: begin cmd_o.op = OP_X; state_d = ST_X2; end
      ST_X2: begin
        cmd_o.op = OP_X2;
        stage_d  = '0;
        state_d  = ST_HN;
      end
      ST_HN: begin cmd_o.op = OP_HN; state_d = ST_HQ; end
      ST_HQ: begin cmd_o.op = OP_HQ; state_d = ST_HR; end
      ST_HR: begin
        cmd_o.op = OP_HR;
        if (stage_q == 3'(HORNER_LAST)) begin
          state_d = status_i.sin ? ST_SIN : ST_CA;
        end else begin
          stage_d = stage_q + 3'd1;
          state_d = ST_HN;
        end
      end
      ST_SIN: begin cmd_o.op = OP_SIN; state_d = ST_CA; end
      ST_CA: begin cmd_o.op = OP_CA; state_d = ST_CB; end
      ST_CB: begin cmd_o.op = OP_CB; state_d = ST_SQ; end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        cnt_d    = '0;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.op = OP_ROOT;
        if (cnt_q == 5'(ROOT_LAST)) begin
          state_d = ST_LEN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_LEN: begin
        cmd_o.op = OP_LEN;
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = ST_FOLD;
        end else begin
          state_d = ST_MH;
        end
      end
      ST_MH: begin cmd_o.op = OP_MH; state_d = ST_ML; end
      ST_ML: begin cmd_o.op = OP_ML; state_d = ST_TOT; end
      ST_TOT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.op    = OP_TOT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_tot_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_TOT) |=> out_valid_q)
    else $error("result not presented after final operation");

  a_root_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && cnt_q == 5'(ROOT_LAST)) |=> (state_q == ST_LEN))
    else $error("root iteration overran");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_BB))
    else $error("accepted beat did not start the sequence");

endmodule

`default_nettype wire

@@ hdl/aats_dpath.sv @@
// Datapath for the angle-to-steps block: configuration registers, shared
// multiplier, angle fold, Horner cosine, square root and residue store.
// Depends on aats_pkg; driven by aats_ctrl.
`default_nettype none

module aats_dpath #(
  parameter int unsigned MACHINES = aats_pkg::MACHINES_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [2:0]         cfg_idx_i,
  input  wire  [31:0]        cfg_wdata_i,
  input  wire                axis_i,
  input  wire  [2:0]         machine_index_i,
  input  wire  signed [14:0] old_angle_i,
  input  wire  signed [14:0] new_angle_i,
  input  aats_pkg::cmd_t     cmd_i,
  output aats_pkg::status_t  status_o,
  output logic signed [31:0] step_count_o,
  output logic               saturated_o
);
  import aats_pkg::*;

  localparam int unsigned DEPTH  = 2 * MACHINES;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [23:0] arm_b_q, arm_c_q, gear_q;
  logic [13:0] zero_q;
  logic        obtuse_q, reverse_q;
  logic [31:0] spl_q;

  // item and working registers
  logic [SLOT_W-1:0]  slot_q;
  logic signed [14:0] old_q, new_q;
  logic [48:0] sq0_q;
  logic [47:0] p_q;
  logic [39:0] glo_q, scale_q;
  logic [11:0] u_q;
  logic        sin_q, neg_q;
  logic [29:0] x_q, x2_q, n_q;
  logic [28:0] q_q;
  logic [30:0] t_q;
  logic [53:0] a_q;
  logic [49:0] term_q, v_q, res_q;
  logic [24:0] lold_q;
  logic [44:0] mh_q;
  logic [57:0] mag_q;
  logic        negm_q;

  // residue store
  logic [16:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [16:0] rd_q;
  logic        rv_q;

  logic [31:0] ma, mb;
  logic [63:0] prod;

  logic [6:0]  k_cur;
  logic [31:0] r_cur;

  assign k_cur = horner_k(sin_q, cmd_i.stage);
  assign r_cur = horner_r(sin_q, cmd_i.stage);
  assign status_o.sin = sin_q;

  // slot from axis and machine index
  logic [6:0]        mm;
  logic [SLOT_W-1:0] slot_d;
  always_comb begin
    mm = {4'd0, machine_index_i};
    for (int i = 0; i < 8; i++) begin
      if (mm >= 7'(MACHINES)) mm = mm - 7'(MACHINES);
    end
    slot_d = SLOT_W'(axis_i ? (7'(MACHINES) + mm) : mm);
  end

  // length difference
  logic signed [25:0] d;
  logic [24:0]        ad;
  assign d  = $signed({1'b0, res_q[24:0]}) - $signed({1'b0, lold_q});
  assign ad = d[25] ? 25'(-d) : d[24:0];

  // shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      OP_BB:   begin ma = 32'(arm_b_q);        mb = 32'(arm_b_q);        end
      OP_CC:   begin ma = 32'(arm_c_q);        mb = 32'(arm_c_q);        end
      OP_BC:   begin ma = 32'(arm_b_q);        mb = 32'(arm_c_q);        end
      OP_GLO:  begin ma = 32'(gear_q);         mb = 32'(spl_q[15:0]);    end
      OP_GHI:  begin ma = 32'(gear_q);         mb = 32'(spl_q[31:16]);   end
      OP_X:    begin ma = 32'(u_q);            mb = RAD_PER_UNIT;        end
      OP_X2:   begin ma = 32'(x_q);            mb = 32'(x_q);            end
      OP_HN:   begin ma = 32'(x2_q);           mb = 32'(t_q);            end
      OP_HQ:   begin ma = 32'(n_q);            mb = r_cur;               end
      OP_HR:   begin ma = 32'(q_q);            mb = 32'(k_cur);          end
      OP_SIN:  begin ma = 32'(x_q);            mb = 32'(t_q);            end
      OP_CA:   begin ma = 32'(p_q[47:24]);     mb = 32'(t_q);            end
      OP_CB:   begin ma = 32'(p_q[23:0]);      mb = 32'(t_q);            end
      OP_MH:   begin ma = 32'(ad);             mb = 32'(scale_q[39:20]); end
      OP_ML:   begin ma = 32'(ad);             mb = 32'(scale_q[19:0]);  end
      default: begin ma = '0;                  mb = '0;                  end
    endcase
  end

  assign prod = 64'(ma) * 64'(mb);

  // angle fold into the first octant
  logic signed [16:0] theta, tm;
  logic [14:0] t0, t1, t2;
  logic [14:0] u_full;
  logic        fold_neg, fold_sin;
  always_comb begin
    if (obtuse_q) theta = $signed({3'b0, zero_q}) + 17'(cmd_i.pass ? new_q : old_q);
    else          theta = $signed({3'b0, zero_q}) - 17'(cmd_i.pass ? new_q : old_q);
    if (theta < 0)                          tm = theta + $signed({2'b0, FULL_TURN});
    else if (theta >= $signed({2'b0, FULL_TURN})) tm = theta - $signed({2'b0, FULL_TURN});
    else                                    tm = theta;
    t0 = tm[14:0];
    t1 = (t0 > HALF_TURN) ? (FULL_TURN - t0) : t0;
    fold_neg = (t1 > QUARTER_TURN);
    t2 = fold_neg ? (HALF_TURN - t1) : t1;
    fold_sin = (t2 > EIGHTH_TURN);
    u_full = fold_sin ? (QUARTER_TURN - t2) : t2;
  end

  // Horner correction: quotient estimate is at most one short
  logic [36:0] hr_rem;
  logic [29:0] hr_q;
  assign hr_rem = 37'(n_q) - prod[36:0];
  assign hr_q   = 30'(q_q) + 30'(hr_rem >= 37'(k_cur));

  // cross term floor(p*m / 2^29)
  logic [54:0] cb_sum;
  logic [49:0] cb_term;
  assign cb_sum  = 55'({a_q[4:0], 24'd0}) + 55'(prod[53:0]);
  assign cb_term = 50'(a_q[53:5]) + 50'(cb_sum[54:29]);

  // root iteration
  logic [5:0]  bpos;
  logic [49:0] bitv;
  logic [50:0] rb;
  assign bpos = 6'd48 - {cmd_i.cnt, 1'b0};
  assign bitv = 50'd1 << bpos;
  assign rb   = {1'b0, res_q} + {1'b0, bitv};

  // final sum, split into whole steps and residue
  logic [16:0]        resid;
  logic signed [59:0] mag_s, total;
  logic               rnd;
  logic signed [43:0] whole;
  logic [16:0]        rem;
  logic               sat_hi, sat_lo;
  always_comb begin
    resid  = rv_q ? rd_q : '0;
    mag_s  = $signed({2'b00, mag_q});
    total  = (negm_q ? -mag_s : mag_s) + $signed({{43{resid[16]}}, resid});
    rnd    = total[59] && (total[15:0] != 16'd0);
    whole  = $signed(total[59:16]) + $signed({43'd0, rnd});
    rem    = {rnd, total[15:0]};
    sat_hi = whole > 44'sd2147483647;
    sat_lo = whole < -44'sd2147483648;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_b_q   <= '0;
      arm_c_q   <= '0;
      zero_q    <= '0;
      obtuse_q  <= 1'b0;
      gear_q    <= 24'd65536;
      reverse_q <= 1'b0;
      spl_q     <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ARM_B:   arm_b_q   <= cfg_wdata_i[23:0];
        REG_ARM_C:   arm_c_q   <= cfg_wdata_i[23:0];
        REG_ZERO:    zero_q    <= cfg_wdata_i[13:0];
        REG_OBTUSE:  obtuse_q  <= cfg_wdata_i[0];
        REG_GEAR:    gear_q    <= cfg_wdata_i[23:0];
        REG_REVERSE: reverse_q <= cfg_wdata_i[0];
        REG_STEPS:   spl_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.op == OP_TOT) begin
      valid_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_TOT) mem_q[slot_q] <= rem;
    if (cmd_i.op == OP_CAPTURE) begin
      rd_q <= mem_q[slot_d];
      rv_q <= valid_q[slot_d];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        slot_q <= slot_d;
        old_q  <= old_angle_i;
        new_q  <= new_angle_i;
      end
      OP_BB:  sq0_q   <= prod[48:0];
      OP_CC:  sq0_q   <= sq0_q + prod[48:0];
      OP_BC:  p_q     <= prod[47:0];
      OP_GLO: glo_q   <= prod[39:0];
      OP_GHI: scale_q <= prod[39:0] + 40'(glo_q[39:16]);
      OP_FOLD: begin
        u_q   <= u_full[11:0];
        sin_q <= fold_sin;
        neg_q <= fold_neg;
      end
      OP_X:   x_q <= prod[29:0];
      OP_X2: begin
        x2_q <= prod[59:30];
        t_q  <= Q30_ONE;
      end
      OP_HN:  n_q <= prod[59:30];
      OP_HQ:  q_q <= prod[60:32];
      OP_HR:  t_q <= Q30_ONE - 31'(hr_q);
      OP_SIN: t_q <= prod[60:30];
      OP_CA:  a_q <= prod[53:0];
      OP_CB:  term_q <= cb_term;
      OP_SQ: begin
        if (neg_q)                       v_q <= 50'(sq0_q) + term_q;
        else if (50'(sq0_q) >= term_q)   v_q <= 50'(sq0_q) - term_q;
        else                             v_q <= '0;
        res_q <= '0;
      end
      OP_ROOT: begin
        if ({1'b0, v_q} >= rb) begin
          v_q   <= v_q - rb[49:0];
          res_q <= (res_q >> 1) + bitv;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      OP_LEN: if (!cmd_i.pass) lold_q <= res_q[24:0];
      OP_MH:  mh_q <= prod[44:0];
      OP_ML: begin
        mag_q  <= {1'b0, mh_q, 12'd0} + 58'(prod[44:8]);
        negm_q <= d[25] ^ reverse_q;
      end
      OP_TOT: begin
        saturated_o <= sat_hi || sat_lo;
        if (sat_hi)      step_count_o <= 32'sh7FFF_FFFF;
        else if (sat_lo) step_count_o <= 32'sh8000_0000;
        else             step_count_o <= $signed(whole[31:0]);
      end
      default: ;
    endcase
  end

  a_residue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_TOT) |-> (rem[16] == total[59] || rem == 17'd0))
    else $error("residue sign differs from total");

  a_horner_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_HR) |-> (hr_rem < 37'(2 * k_cur)))
    else $error("quotient estimate off by more than one");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FOLD) |=> (u_q <= 12'(EIGHTH_TURN)))
    else $error("folded angle outside first octant");

endmodule

`default_nettype wire

@@ hdl/actuator_angle_to_steps.sv @@
// Top level of the actuator angle-to-steps converter: joins the sequencer
// and the datapath. Depends on aats_pkg, aats_ctrl and aats_dpath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per move: axis,
//   machine index, old and new joint angle. Output channel (out_valid_o /
//   out_stall_i) carries one beat back: whole steps and a saturation flag.
//   A beat moves on a rising edge with valid high and stall low.
//   Each move takes two length evaluations, each a 25-step square root
//   plus five Horner stages on one shared 32x32 multiplier.
//   A new move is taken only once the sequencer has finished the last one;
//   in_stall_o is low only while the sequencer is idle.
//   The result sits in an output register, so a new item is taken while the
//   previous result still waits; a finished item holds in its last step
//   until that register is free.
//   Reset: configuration returns to its defaults (unit gear ratio and unit
//   steps per length, everything else zero) and all step residues read as
//   zero; there is no clearing pass. Configuration writes are taken at any
//   time but must only be issued while the block is idle.
`default_nettype none

module actuator_angle_to_steps #(
  parameter int unsigned MACHINES = aats_pkg::MACHINES_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [2:0]         cfg_idx_i,
  input  wire  [31:0]        cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                axis_i,
  input  wire  [2:0]         machine_index_i,
  input  wire  signed [14:0] old_angle_i,
  input  wire  signed [14:0] new_angle_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] step_count_o,
  output logic               saturated_o
);
  import aats_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: owns both handshakes and the step order
  aats_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: arithmetic, configuration and residue store
  aats_dpath #(
    .MACHINES (MACHINES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .axis_i          (axis_i),
    .machine_index_i (machine_index_i),
    .old_angle_i     (old_angle_i),
    .new_angle_i     (new_angle_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .step_count_o    (step_count_o),
    .saturated_o     (saturated_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for actuator_angle_to_steps: drives random and directed moves,
// predicts step counts with a fixed-point model of the block and checks them.
// Depends on aats_pkg and the actuator_angle_to_steps RTL.
`timescale 1ns / 100ps

class step_scoreboard;
  logic signed [31:0] want_steps[$];
  logic               want_sat[$];
  int                 mismatches;

  // print one line per mismatch and count it
  task report(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // note an accepted move and its predicted result
  function void note_move(logic signed [31:0] steps, logic sat);
    want_steps.push_back(steps);
    want_sat.push_back(sat);
  endfunction

  // check a result beat against the oldest prediction
  task check_result(logic signed [31:0] steps, logic sat);
    logic signed [31:0] es;
    logic               ef;
    if (want_steps.size() == 0) begin
      report($sformatf("result beat with no move pending, steps %0d", steps));
      return;
    end
    es = want_steps.pop_front();
    ef = want_sat.pop_front();
    if (steps !== es)
      report($sformatf("step_count got %0d want %0d", steps, es));
    if (sat !== ef)
      report($sformatf("saturated got %0b want %0b", sat, ef));
  endtask
endclass

module tb_top;
  import aats_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               axis_i;
  logic [2:0]         machine_index_i;
  logic signed [14:0] old_angle_i;
  logic signed [14:0] new_angle_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] step_count_o;
  logic               saturated_o;

  actuator_angle_to_steps u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .axis_i, .machine_index_i,
    .old_angle_i, .new_angle_i,
    .out_valid_o, .out_stall_i, .step_count_o, .saturated_o
  );

  step_scoreboard sb;

  // predictor copy of the configuration and residue store
  logic [23:0] m_arm_b, m_arm_c, m_gear;
  logic [13:0] m_zero;
  logic        m_obtuse, m_reverse;
  logic [31:0] m_steps;
  longint      m_residue[2*MACHINES_DEF];

  // stimulus control
  bit quiet;        // no idling in the last part of the run
  bit long_hold;    // receiver holds off for a long stretch

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Horner stage: ONE - floor(floor(x2*t / 2^30) / k)
  function automatic longint unsigned horner(longint unsigned x2, longint unsigned t,
                                             longint unsigned k);
    return 64'd1073741824 - (((x2 * t) >> 30) / k);
  endfunction

  // magnitude of cos or sin series on a folded angle, Q30
  function automatic longint unsigned series(longint unsigned u, bit use_sin);
    longint unsigned x, x2, t;
    x  = u * 64'd292818;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    if (use_sin) begin
      t = horner(x2, t, 110); t = horner(x2, t, 72); t = horner(x2, t, 42);
      t = horner(x2, t, 20);  t = horner(x2, t, 6);
      return (x * t) >> 30;
    end
    t = horner(x2, t, 90); t = horner(x2, t, 56); t = horner(x2, t, 30);
    t = horner(x2, t, 12); t = horner(x2, t, 2);
    return t;
  endfunction

  // signed Q30 cosine of an angle in 1/64 degree
  function automatic longint cosine_q30(int theta);
    int t;
    bit neg;
    longint unsigned m;
    t = theta % 23040;
    neg = 0;
    if (t < 0) t += 23040;
    if (t > 11520) t = 23040 - t;
    if (t > 5760) begin
      neg = 1;
      t = 11520 - t;
    end
    if (t <= 2880) m = series(t, 0);
    else m = series(5760 - t, 1);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // leadscrew length in Q.8 for a joint angle
  function automatic longint screw_len(int angle);
    int theta;
    longint cq, sq;
    longint unsigned m, p, a, bb, term;
    theta = m_obtuse ? int'(m_zero) + angle : int'(m_zero) - angle;
    cq = cosine_q30(theta);
    m = cq < 0 ? -cq : cq;
    p = longint'(m_arm_b) * longint'(m_arm_c);
    a = (p >> 24) * m;
    bb = (p & 64'hFFFFFF) * m;
    term = (a >> 5) + ((((a & 31) << 24) + bb) >> 29);
    sq = longint'(m_arm_b) * m_arm_b + longint'(m_arm_c) * m_arm_c;
    if (cq >= 0) sq -= longint'(term); else sq += longint'(term);
    if (sq < 0) sq = 0;
    return longint'(floor_root(sq));
  endfunction

  // predict whole steps for a move and advance the residue
  task automatic predict_move(logic ax, logic [2:0] mi, logic signed [14:0] oa,
                              logic signed [14:0] na);
    int slot;
    longint d, total, whole;
    longint unsigned ad, scale, mag;
    bit neg, sat;
    slot = ax * MACHINES_DEF + (mi % MACHINES_DEF);
    d = screw_len(na) - screw_len(oa);
    ad = d < 0 ? -d : d;
    scale = (longint'(m_steps) * longint'(m_gear)) >> 16;
    mag = ((ad * (scale >> 20)) << 12) + ((ad * (scale & 64'hFFFFF)) >> 8);
    neg = (d < 0) != m_reverse;
    total = (neg ? -longint'(mag) : longint'(mag)) + m_residue[slot];
    whole = total / 65536;
    m_residue[slot] = total - whole * 65536;
    sat = 0;
    if (whole > 64'sd2147483647) begin
      whole = 64'sd2147483647;
      sat = 1;
    end
    if (whole < -64'sd2147483648) begin
      whole = -64'sd2147483648;
      sat = 1;
    end
    sb.note_move(whole[31:0], sat);
  endtask

  // write a register at a falling edge and mirror it into the predictor
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ARM_B:   m_arm_b   = val[23:0];
      REG_ARM_C:   m_arm_c   = val[23:0];
      REG_ZERO:    m_zero    = val[13:0];
      REG_OBTUSE:  m_obtuse  = val[0];
      REG_GEAR:    m_gear    = val[23:0];
      REG_REVERSE: m_reverse = val[0];
      REG_STEPS:   m_steps   = val;
      default: ;
    endcase
  endtask

  task automatic setup(logic [23:0] b, logic [23:0] c, logic [13:0] z, logic ob,
                       logic [23:0] g, logic rv, logic [31:0] s);
    write_reg(REG_ARM_B, b);
    write_reg(REG_ARM_C, c);
    write_reg(REG_ZERO, z);
    write_reg(REG_OBTUSE, ob);
    write_reg(REG_GEAR, g);
    write_reg(REG_REVERSE, rv);
    write_reg(REG_STEPS, s);
  endtask

  // offer one beat and hold it until accepted; optional idle burst first
  task automatic send_move(logic ax, logic [2:0] mi, logic signed [14:0] oa,
                           logic signed [14:0] na);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    in_valid_i      <= 1'b1;
    axis_i          <= ax;
    machine_index_i <= mi;
    old_angle_i     <= oa;
    new_angle_i     <= na;
    do @(posedge clk_i); while (in_stall_o);
    predict_move(ax, mi, oa, na);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic signed [14:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 15'sd11520;
      1: return -15'sd11520;
      2: return 15'($urandom);          // any 15-bit pattern, periodic cosine
      default: return 15'($signed($urandom_range(0, 23040)) - 11520);
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.want_steps.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  // receiver: random stall bursts, a forced long hold-off, none when quiet
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (600) @(negedge clk_i);
        long_hold = 0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // sample result beats at the rising edge
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(step_count_o, saturated_o);

  initial begin
    int n;
    sb = new();
    quiet = 0; long_hold = 0;
    cfg_we_i = 0; cfg_idx_i = REG_ARM_B; cfg_wdata_i = '0;
    in_valid_i = 0; axis_i = 0; machine_index_i = '0;
    old_angle_i = '0; new_angle_i = '0;
    m_arm_b = 0; m_arm_c = 0; m_zero = 0; m_obtuse = 0;
    m_gear = 24'd65536; m_reverse = 0; m_steps = 32'd65536;
    foreach (m_residue[i]) m_residue[i] = 0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults: zero arms give zero length, so nothing moves
    send_move(0, 0, 15'sd11520, -15'sd11520);
    wait_drained();
    setup(24'd25600, 24'd19200, 14'd5760, 0, 24'd65536, 0, 32'd200 << 16);
    // extremes of the angles and both axes, several machine indexes
    send_move(0, 7, -15'sd11520, 15'sd11520);
    send_move(1, 0, 15'sd0, 15'sd5760);
    send_move(1, 5, 15'sd2880, 15'sd2881);
    send_move(0, 3, 15'sd16383, -15'sd16384);   // outside half a turn
    send_move(0, 3, 15'sd100, 15'sd101);         // residue build-up
    send_move(0, 3, 15'sd101, 15'sd102);
    wait_drained();
    // obtuse, reversed, equal arms: squared length near zero gets clamped
    setup(24'hFFFFFF, 24'hFFFFFF, 14'd0, 1, 24'd65536, 1, 32'd65536);
    send_move(1, 2, 15'sd0, 15'sd1);
    send_move(1, 2, 15'sd1, 15'sd0);
    send_move(0, 6, 15'sd11520, 15'sd0);
    wait_drained();
    // saturation: largest scale
    setup(24'hFFFFFF, 24'hFFFFFF, 14'd11520, 0, 24'hFFFFFF, 0, 32'hFFFF_FFFF);
    send_move(0, 1, 15'sd11520, 15'sd0);
    send_move(1, 1, 15'sd0, 15'sd11520);
    send_move(0, 4, 15'sd0, 15'sd1);
    wait_drained();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);        // ignored index

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      setup(24'($urandom), 24'($urandom), 14'($urandom_range(0, 11520)), 1'($urandom),
            (ph == 3) ? 24'hFFFFFF : 24'($urandom_range(0, 24'h40000)), 1'($urandom),
            (ph == 3) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0100_0000));
      n = 85;
      if (ph == 2) long_hold = 1;  // receiver holds off, sender keeps offering
      if (ph == 7) quiet = 1;
      for (int i = 0; i < n; i++)
        send_move(1'($urandom), 3'($urandom), rand_angle(), rand_angle());
      wait_drained();               // sender pauses until all results are in
    end
    if (sb.mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ actuator_angle_to_steps.f @@
hdl/aats_pkg.sv
hdl/aats_ctrl.sv
hdl/aats_dpath.sv
hdl/actuator_angle_to_steps.sv
tb/tb_top.sv
